// ===== rtl/c3zp_pkg.sv =====
// ----------------------------------------------------------------------------
// c3zp_pkg
// Shared types and constants of the 3x3 zero padded convolution block:
// register indexes, fixed field widths and result job positions.
// ----------------------------------------------------------------------------
`default_nettype none

package c3zp_pkg;

    // Fixed field widths
    localparam int PIX_BITS     = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int FRAC_W       = 4;
    localparam int DIM_BITS     = 11;
    localparam int ROW_BITS     = 10;
    localparam int MAX_HEIGHT   = 1024;

    // Window geometry
    localparam int KSIZE    = 3;
    localparam int WIN_TAPS = KSIZE * KSIZE;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_MID  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAC_BITS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd5;

    // Result jobs, one bit each, issued in raster order (low bit first)
    localparam int NUM_JOBS = 4;
    localparam int JOB_MM   = 0;    // centered on window middle
    localparam int JOB_MR   = 1;    // right padding column
    localparam int JOB_BM   = 2;    // bottom padding row
    localparam int JOB_BR   = 3;    // bottom right corner, ends the frame

    typedef logic [PIX_BITS-1:0] pix_t;
    typedef logic [NUM_JOBS-1:0] job_mask_t;

endpackage

`default_nettype wire

// ===== rtl/conv3x3_zero_pad_u8.sv =====
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_u8
// Streaming 3x3 correlation of an 8-bit raster image with zero padding,
// signed fixed point coefficients, round half to even and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid/in_stall/pixel; a transfer
//   happens on a clock edge with in_valid high and in_stall low. Results
//   leave on out_valid/out_stall with value, run_last (last result of one
//   input pixel) and frame_end (bottom right result of the frame).
//   Configuration is written through cfg_write/cfg_index/cfg_data while
//   the block is idle.
//   A pixel is registered in stage 1; its results pass F1 to F4 and the
//   output register. Throughput: one pixel per clock while each pixel
//   yields at most one result and the receiver does not stall. All results
//   go through one shared filter pipeline, so a pixel yielding n results
//   (row end, last row, frame end) holds the input until its last result
//   issues. Two image rows live in one line memory with registered read,
//   not cleared by reset; stale reads are masked. Reset restores register
//   defaults and the frame start. When the receiver stalls, the filter
//   stages fill behind the output register and only then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_zero_pad_u8
    import c3zp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 12
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration write port
    input  wire                          cfg_write,
    input  wire [CFG_IDX_BITS-1:0]       cfg_index,
    input  wire [3*COEF_BITS-1:0]        cfg_data,
    // pixel input
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [PIX_BITS-1:0]           pixel,
    // result output
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [PIX_BITS-1:0]          value,
    output logic                         run_last,
    output logic                         frame_end
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (XW + 1 > DIM_BITS) ? XW + 1 : DIM_BITS;
    localparam int CW = 3 * COEF_BITS;
    localparam int PW = COEF_BITS + PIX_BITS + 1;
    localparam int RW = PW + 2;
    localparam int SW = PW + 4;
    localparam int MW = 2 * PIX_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0]       coef_top_reg;
    logic [CW-1:0]       coef_mid_reg;
    logic [CW-1:0]       coef_bot_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= '0;
            coef_mid_reg <= CW'(1) << COEF_BITS;
            coef_bot_reg <= '0;
            frac_reg     <= '0;
            width_reg    <= DIM_BITS'(640);
            height_reg   <= DIM_BITS'(480);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COEF_TOP:  coef_top_reg <= cfg_data;
                REG_COEF_MID:  coef_mid_reg <= cfg_data;
                REG_COEF_BOT:  coef_bot_reg <= cfg_data;
                REG_FRAC_BITS: frac_reg     <= cfg_data[FRAC_W-1:0];
                REG_WIDTH:     width_reg    <= cfg_data[DIM_BITS-1:0];
                REG_HEIGHT:    height_reg   <= cfg_data[DIM_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic                in_xfer;
    logic [XW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [WW-1:0]       w_eff;
    logic [DIM_BITS-1:0] h_eff;
    logic                eol_in, last_in;

    logic                s1_v_reg;
    pix_t                s1_px_reg;
    logic [XW-1:0]       s1_x_reg;
    logic                s1_col0_reg, s1_y1_reg, s1_y2_reg, s1_eol_reg, s1_last_reg;
    logic                s1_go;

    logic [MW-1:0]       line_mem [MAX_WIDTH];
    logic [MW-1:0]       mem_rd_reg;
    logic                fwd_hit_reg;
    logic [MW-1:0]       fwd_word_reg;
    logic [MW-1:0]       rd_word, wr_word;
    pix_t                row1_px, row2_px;

    pix_t                win_reg  [WIN_TAPS];
    pix_t                win_next [WIN_TAPS];

    job_mask_t           pend_reg, pend_next, pend_load, job_sel;
    logic                job_issue, job_last;
    pix_t                tap_mm [WIN_TAPS];
    pix_t                tap_mr [WIN_TAPS];
    pix_t                tap_bm [WIN_TAPS];
    pix_t                tap_br [WIN_TAPS];
    pix_t                tap    [WIN_TAPS];
    logic signed [COEF_BITS-1:0] coef [WIN_TAPS];

    logic                f1_v_reg, f1_last_reg, f1_fe_reg, f1_rdy;
    pix_t                f1_tap_reg [WIN_TAPS];
    logic                f2_v_reg, f2_last_reg, f2_fe_reg, f2_rdy;
    logic signed [PW-1:0] f2_prod_reg [WIN_TAPS];
    logic                f3_v_reg, f3_last_reg, f3_fe_reg, f3_rdy;
    logic signed [RW-1:0] f3_rsum_reg [KSIZE];
    logic                f4_v_reg, f4_last_reg, f4_fe_reg, f4_rdy;
    logic signed [SW-1:0] f4_sum_reg;
    logic                out_v_reg, out_last_reg, out_fe_reg, out_rdy;
    pix_t                out_val_reg;
    pix_t                rnd_val;

    // ------------------------------------------------------------------
    // Input side: position counters and frame geometry
    // ------------------------------------------------------------------
    assign in_stall = s1_v_reg && !s1_go;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        // width clamped to 1..MAX_WIDTH, height to 1..MAX_HEIGHT
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = DIM_BITS'(1);
        else if (height_reg > DIM_BITS'(MAX_HEIGHT))
            h_eff = DIM_BITS'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        eol_in  = (WW'(col_reg) + WW'(1)) >= w_eff;
        last_in = (DIM_BITS'(row_reg) + DIM_BITS'(1)) >= h_eff;

        col_next = col_reg;
        row_next = row_reg;
        if (in_xfer)
        begin
            if (eol_in)
            begin
                col_next = '0;
                row_next = last_in ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            s1_v_reg    <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_xfer)
            begin
                s1_v_reg    <= 1'b1;
                // same entry written by the item leaving stage 1 this cycle
                fwd_hit_reg <= s1_go && (col_reg == s1_x_reg);
            end
            else if (s1_go)
            begin
                s1_v_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_px_reg    <= pixel;
            s1_x_reg     <= col_reg;
            s1_col0_reg  <= (col_reg == '0);
            s1_y1_reg    <= (row_reg != '0);
            s1_y2_reg    <= (row_reg > ROW_BITS'(1));
            s1_eol_reg   <= eol_in;
            s1_last_reg  <= last_in;
            fwd_word_reg <= wr_word;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one word per column, {row y-2, row y-1}
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_go)
            line_mem[s1_x_reg] <= wr_word;
        if (in_xfer)
            mem_rd_reg <= line_mem[col_reg];
    end

    assign rd_word = fwd_hit_reg ? fwd_word_reg : mem_rd_reg;
    assign row1_px = rd_word[PIX_BITS-1:0];
    assign row2_px = rd_word[MW-1:PIX_BITS];
    assign wr_word = {row1_px, s1_px_reg};

    // ------------------------------------------------------------------
    // Window update: shift left, new column from memory and input
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            win_next[r*KSIZE]     = s1_col0_reg ? '0 : win_reg[r*KSIZE + 1];
            win_next[r*KSIZE + 1] = s1_col0_reg ? '0 : win_reg[r*KSIZE + 2];
        end
        win_next[2] = s1_y2_reg ? row2_px : '0;
        win_next[5] = s1_y1_reg ? row1_px : '0;
        win_next[8] = s1_px_reg;
    end

    // ------------------------------------------------------------------
    // Result sequencer: one filter job per cycle unless F1 stalls, raster order
    // ------------------------------------------------------------------
    always_comb
    begin
        pend_load         = '0;
        pend_load[JOB_MM] = s1_y1_reg && !s1_col0_reg;
        pend_load[JOB_MR] = s1_y1_reg && s1_eol_reg;
        pend_load[JOB_BM] = s1_last_reg && !s1_col0_reg;
        pend_load[JOB_BR] = s1_last_reg && s1_eol_reg;

        job_sel   = pend_reg & (~pend_reg + job_mask_t'(1));
        job_last  = (pend_reg & ~job_sel) == '0;
        job_issue = (pend_reg != '0) && f1_rdy;
        s1_go     = s1_v_reg && ((pend_reg == '0) || (job_issue && job_last));

        if (s1_go)
            pend_next = pend_load;
        else if (job_issue)
            pend_next = pend_reg & ~job_sel;
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            for (int i = 0; i < WIN_TAPS; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (s1_go)
                win_reg <= win_next;
        end
    end

    // Padded tap sets and coefficient unpacking per kernel position
    for (genvar dr = 0; dr < KSIZE; dr++)
    begin : g_row
        for (genvar dc = 0; dc < KSIZE; dc++)
        begin : g_col
            assign tap_mm[dr*KSIZE + dc] = win_reg[dr*KSIZE + dc];

            if (dc < KSIZE - 1)
            begin : g_mr
                assign tap_mr[dr*KSIZE + dc] = win_reg[dr*KSIZE + dc + 1];
            end
            else
            begin : g_mr_pad
                assign tap_mr[dr*KSIZE + dc] = '0;
            end

            if (dr < KSIZE - 1)
            begin : g_bm
                assign tap_bm[dr*KSIZE + dc] = win_reg[(dr + 1)*KSIZE + dc];
            end
            else
            begin : g_bm_pad
                assign tap_bm[dr*KSIZE + dc] = '0;
            end

            if (dr < KSIZE - 1 && dc < KSIZE - 1)
            begin : g_br
                assign tap_br[dr*KSIZE + dc] = win_reg[(dr + 1)*KSIZE + dc + 1];
            end
            else
            begin : g_br_pad
                assign tap_br[dr*KSIZE + dc] = '0;
            end

            if (dr == 0)
            begin : g_ctop
                assign coef[dr*KSIZE + dc] = coef_top_reg[dc*COEF_BITS +: COEF_BITS];
            end
            else if (dr == 1)
            begin : g_cmid
                assign coef[dr*KSIZE + dc] = coef_mid_reg[dc*COEF_BITS +: COEF_BITS];
            end
            else
            begin : g_cbot
                assign coef[dr*KSIZE + dc] = coef_bot_reg[dc*COEF_BITS +: COEF_BITS];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            tap[i] = ({PIX_BITS{job_sel[JOB_MM]}} & tap_mm[i])
                   | ({PIX_BITS{job_sel[JOB_MR]}} & tap_mr[i])
                   | ({PIX_BITS{job_sel[JOB_BM]}} & tap_bm[i])
                   | ({PIX_BITS{job_sel[JOB_BR]}} & tap_br[i]);
        end
    end

    // ------------------------------------------------------------------
    // Filter pipeline handshake: a stage takes data when empty or moving
    // ------------------------------------------------------------------
    assign out_rdy = !out_v_reg || !out_stall;
    assign f4_rdy  = !f4_v_reg || out_rdy;
    assign f3_rdy  = !f3_v_reg || f4_rdy;
    assign f2_rdy  = !f2_v_reg || f3_rdy;
    assign f1_rdy  = !f1_v_reg || f2_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            f3_v_reg  <= 1'b0;
            f4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (f1_rdy)
                f1_v_reg <= job_issue;
            if (f2_rdy)
                f2_v_reg <= f1_v_reg;
            if (f3_rdy)
                f3_v_reg <= f2_v_reg;
            if (f4_rdy)
                f4_v_reg <= f3_v_reg;
            if (out_rdy)
                out_v_reg <= f4_v_reg;
        end
    end

    // Stage F1: selected taps
    always_ff @(posedge clk)
    begin
        if (f1_rdy && job_issue)
        begin
            f1_tap_reg  <= tap;
            f1_last_reg <= job_last;
            f1_fe_reg   <= job_sel[JOB_BR];
        end
    end

    // Stage F2: nine products
    always_ff @(posedge clk)
    begin
        if (f2_rdy && f1_v_reg)
        begin
            for (int i = 0; i < WIN_TAPS; i++)
                f2_prod_reg[i] <= coef[i] * $signed({1'b0, f1_tap_reg[i]});
            f2_last_reg <= f1_last_reg;
            f2_fe_reg   <= f1_fe_reg;
        end
    end

    // Stage F3: row sums
    always_ff @(posedge clk)
    begin
        if (f3_rdy && f2_v_reg)
        begin
            for (int r = 0; r < KSIZE; r++)
                f3_rsum_reg[r] <= RW'(f2_prod_reg[r*KSIZE])
                                + RW'(f2_prod_reg[r*KSIZE + 1])
                                + RW'(f2_prod_reg[r*KSIZE + 2]);
            f3_last_reg <= f2_last_reg;
            f3_fe_reg   <= f2_fe_reg;
        end
    end

    // Stage F4: total sum
    always_ff @(posedge clk)
    begin
        if (f4_rdy && f3_v_reg)
        begin
            f4_sum_reg  <= SW'(f3_rsum_reg[0]) + SW'(f3_rsum_reg[1])
                         + SW'(f3_rsum_reg[2]);
            f4_last_reg <= f3_last_reg;
            f4_fe_reg   <= f3_fe_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shift, round half to even, clamp to 0..255
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [SW-1:0] u_sum;
        logic [SW-1:0] quo;
        logic [SW-1:0] rem;
        logic [SW-1:0] half;
        logic [SW-1:0] quo_rnd;
        logic          rnd_up;

        u_sum   = f4_sum_reg;
        quo     = u_sum >> frac_reg;
        rem     = u_sum & ~({SW{1'b1}} << frac_reg);
        half    = (frac_reg == '0) ? '0 : (SW'(1) << (frac_reg - FRAC_W'(1)));
        rnd_up  = (frac_reg != '0) && ((rem > half) || ((rem == half) && quo[0]));
        quo_rnd = quo + SW'(rnd_up);

        if (f4_sum_reg <= 0)
            rnd_val = '0;
        else if (quo_rnd > SW'(255))
            rnd_val = '1;
        else
            rnd_val = quo_rnd[PIX_BITS-1:0];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_rdy && f4_v_reg)
        begin
            out_val_reg  <= rnd_val;
            out_last_reg <= f4_last_reg;
            out_fe_reg   <= f4_fe_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign value     = out_val_reg;
    assign run_last  = out_last_reg;
    assign frame_end = out_fe_reg;

endmodule

`default_nettype wire
